FILE: rtl/chist_pkg.sv
// ----------------------------------------------------------------------------
// chist_pkg
// Shared constants, opcodes and types of the compressed length histogram.
// ----------------------------------------------------------------------------
package chist_pkg;

  localparam int PAGE_BYTES  = 4096;
  localparam int BIN_STEP    = 16;
  localparam int LAST_BIN    = PAGE_BYTES / BIN_STEP;
  localparam int NUM_BINS    = LAST_BIN + 1;
  localparam int BIN_W       = $clog2(NUM_BINS);
  // A write is good when its bin times BIN_STEP is at most half a page.
  localparam int GOOD_BIN    = (PAGE_BYTES / 2) / BIN_STEP;

  localparam int FUNC_W      = 2;
  localparam int LEN_W       = 16;
  localparam int SEL_W       = 9;
  localparam int CNT_W       = 32;
  localparam int PCT_W       = 7;
  localparam int PCT_SCALE   = 100;
  localparam int PROD_W      = CNT_W + PCT_W;
  localparam int STEP_W      = $clog2(PCT_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_BIN     = 2'd2,
    FUNC_SUMMARY = 2'd3
  } func_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    func_t            func;
    logic [BIN_W-1:0] bin;
    logic             good;
    logic             in_range;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

FILE: rtl/compressed_length_histogram.sv
// ----------------------------------------------------------------------------
// compressed_length_histogram
// Histogram of compressed page lengths with read, write and good-write counts.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with func, page_len and bin_select.
// Read and write events give no result; a bin query or a summary query gives
// one result on out_valid/out_stall. The front classifies each request and
// puts it in a four-entry queue; in_stall is high only while that queue is
// full. The back takes one request at a time from the queue: a read event
// is counted as it is taken; a write event does a registered read of the bin
// store, then a write of the incremented count; a bin query reads the bin
// store and then loads the output register; a summary reads the overflow bin
// and takes the percentage from a 7-step restoring divide unless there are
// no writes or every write was good. No new request is taken until a write
// is done. A result is held in an output register while out_stall is high;
// the back keeps working on events and waits only when a second result is
// ready before the first was taken. Reset clears all counters and the
// per-bin valid bits, so the block takes requests right after.
// ----------------------------------------------------------------------------
module compressed_length_histogram (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [chist_pkg::FUNC_W-1:0] func,
  input  logic [chist_pkg::LEN_W-1:0]  page_len,
  input  logic [chist_pkg::SEL_W-1:0]  bin_select,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [chist_pkg::CNT_W-1:0] bin_count,
  output logic [chist_pkg::CNT_W-1:0] reads_total,
  output logic [chist_pkg::CNT_W-1:0] writes_total,
  output logic [chist_pkg::CNT_W-1:0] overflow_count,
  output logic [chist_pkg::PCT_W-1:0] good_percent,
  output logic                        no_writes
);
  import chist_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign in_stall = q_full;

  chist_front u_front (
    .func       (func),
    .page_len   (page_len),
    .bin_select (bin_select),
    .cmd        (front_cmd)
  );

  chist_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (q_cmd)
  );

  chist_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bin_count      (bin_count),
    .reads_total    (reads_total),
    .writes_total   (writes_total),
    .overflow_count (overflow_count),
    .good_percent   (good_percent),
    .no_writes      (no_writes)
  );

endmodule

FILE: rtl/chist_front.sv
// ----------------------------------------------------------------------------
// chist_front
// Classifies an incoming request: works out the bin of a write, whether the
// write is good, and the bin that a query reads.
// ----------------------------------------------------------------------------
module chist_front (
  input  logic [chist_pkg::FUNC_W-1:0] func,
  input  logic [chist_pkg::LEN_W-1:0]  page_len,
  input  logic [chist_pkg::SEL_W-1:0]  bin_select,
  output chist_pkg::cmd_t              cmd
);
  import chist_pkg::*;

  logic [LEN_W:0]   rounded;
  logic [LEN_W:0]   quot;
  logic [BIN_W-1:0] write_bin;
  logic             sel_ok;

  // Ceiling division by the bin step, then clamp into the overflow bin.
  assign rounded   = {1'b0, page_len} + (LEN_W+1)'(BIN_STEP - 1);
  assign quot      = (LEN_W+1)'(rounded / BIN_STEP);
  assign write_bin = (quot > (LEN_W+1)'(LAST_BIN)) ? BIN_W'(LAST_BIN) : quot[BIN_W-1:0];
  assign sel_ok    = ({1'b0, bin_select} <= (SEL_W+1)'(LAST_BIN));

  always_comb begin
    cmd.func     = func_t'(func);
    cmd.bin      = '0;
    cmd.good     = 1'b0;
    cmd.in_range = 1'b1;
    case (func_t'(func))
      FUNC_WRITE: begin
        cmd.bin  = write_bin;
        cmd.good = (quot <= (LEN_W+1)'(GOOD_BIN));
      end
      FUNC_BIN: begin
        // An out-of-range bin reads entry zero and is masked to zero later.
        cmd.bin      = sel_ok ? BIN_W'(bin_select) : '0;
        cmd.in_range = sel_ok;
      end
      FUNC_SUMMARY: begin
        cmd.bin = BIN_W'(LAST_BIN);
      end
      default: begin
        cmd.bin = '0;
      end
    endcase
  end

endmodule

FILE: rtl/chist_queue.sv
// ----------------------------------------------------------------------------
// chist_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module chist_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  chist_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output chist_pkg::cmd_t pop_cmd
);
  import chist_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

FILE: rtl/chist_back.sv
// ----------------------------------------------------------------------------
// chist_back
// Executes requests: counter updates, bin read-modify-write, queries and the
// summary percentage by a short restoring divide. Holds the output register.
// ----------------------------------------------------------------------------
module chist_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  chist_pkg::cmd_t             q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [chist_pkg::CNT_W-1:0] bin_count,
  output logic [chist_pkg::CNT_W-1:0] reads_total,
  output logic [chist_pkg::CNT_W-1:0] writes_total,
  output logic [chist_pkg::CNT_W-1:0] overflow_count,
  output logic [chist_pkg::PCT_W-1:0] good_percent,
  output logic                        no_writes
);
  import chist_pkg::*;

  back_state_t state;
  back_state_t state_next;

  // Bin store with one valid bit per entry so reset clears it at once.
  logic [CNT_W-1:0] mem [NUM_BINS];
  logic [CNT_W-1:0] rd_data;
  logic [NUM_BINS-1:0] bin_valid;

  cmd_t             cmd;
  logic [CNT_W-1:0] read_counter;
  logic [CNT_W-1:0] write_counter;
  logic [CNT_W-1:0] good_counter;

  logic [CNT_W-1:0] res_bin;
  logic [CNT_W-1:0] res_reads;
  logic [CNT_W-1:0] res_writes;
  logic [CNT_W-1:0] res_over;
  logic [PCT_W-1:0] res_pct;
  logic             res_nowr;

  logic [CNT_W-1:0]  rem;
  logic [PCT_W-1:0]  low_bits;
  logic [STEP_W-1:0] step;

  logic [CNT_W-1:0]  cur;
  logic [PROD_W-1:0] product;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic              out_free;
  logic              div_last;

  // Controls from the sequencer.
  logic take;
  logic count_read;
  logic mem_read;
  logic exec;
  logic div_step;
  logic load_out;

  assign cur       = bin_valid[cmd.bin] ? rd_data : '0;
  assign product   = PROD_W'(good_counter) * PROD_W'(PCT_SCALE);
  assign rem_shift = {rem, low_bits[PCT_W-1]};
  assign trial     = rem_shift - {1'b0, write_counter};
  assign qbit      = !trial[CNT_W];
  assign out_free  = !out_valid || !out_stall;
  assign div_last  = (step == STEP_W'(PCT_W - 1));
  assign q_pop     = take;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty && q_cmd.func != FUNC_READ) state_next = ST_DATA;
      end
      ST_DATA: begin
        if (cmd.func == FUNC_WRITE) begin
          state_next = ST_IDLE;
        end else if (cmd.func == FUNC_SUMMARY && write_counter != '0 &&
                     good_counter < write_counter) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    take       = 1'b0;
    count_read = 1'b0;
    mem_read   = 1'b0;
    exec       = 1'b0;
    div_step   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        take       = !q_empty;
        count_read = !q_empty && q_cmd.func == FUNC_READ;
        mem_read   = !q_empty && q_cmd.func != FUNC_READ;
      end
      ST_DATA: exec     = 1'b1;
      ST_DIV:  div_step = 1'b1;
      ST_OUT:  load_out = out_free;
      default: take     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory port: registered read, single write.
  always_ff @(posedge clk) begin
    if (mem_read) rd_data <= mem[q_cmd.bin];
    if (exec && cmd.func == FUNC_WRITE) mem[cmd.bin] <= cur + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid     <= '0;
      read_counter  <= '0;
      write_counter <= '0;
      good_counter  <= '0;
    end else begin
      if (count_read) read_counter <= read_counter + 1'b1;
      if (exec && cmd.func == FUNC_WRITE) begin
        bin_valid[cmd.bin] <= 1'b1;
        write_counter      <= write_counter + 1'b1;
        if (cmd.good) good_counter <= good_counter + 1'b1;
      end
    end
  end

  // Request datapath and result staging.
  always_ff @(posedge clk) begin
    if (mem_read) cmd <= q_cmd;
    if (exec) begin
      res_bin    <= '0;
      res_reads  <= '0;
      res_writes <= '0;
      res_over   <= '0;
      res_pct    <= '0;
      res_nowr   <= 1'b0;
      if (cmd.func == FUNC_BIN) begin
        res_bin <= cmd.in_range ? cur : '0;
      end else if (cmd.func == FUNC_SUMMARY) begin
        res_reads  <= read_counter;
        res_writes <= write_counter;
        res_over   <= cur;
        if (write_counter == '0) begin
          res_nowr <= 1'b1;
        end else if (good_counter >= write_counter) begin
          res_pct <= PCT_W'(PCT_SCALE);
        end
      end
      // The scaled count is below 128 times the divisor here, so its upper
      // bits already form a remainder smaller than the divisor.
      rem      <= product[PROD_W-1:PCT_W];
      low_bits <= product[PCT_W-1:0];
      step     <= '0;
    end
    if (div_step) begin
      rem      <= qbit ? trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      low_bits <= {low_bits[PCT_W-2:0], 1'b0};
      res_pct  <= {res_pct[PCT_W-2:0], qbit};
      step     <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      bin_count      <= res_bin;
      reads_total    <= res_reads;
      writes_total   <= res_writes;
      overflow_count <= res_over;
      good_percent   <= res_pct;
      no_writes      <= res_nowr;
    end
  end

endmodule
